### hw/rtl/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg: shared types and constants of the RGB fade engine
// Action codes, field widths and the beat structs of both channels.
// ----------------------------------------------------------------------------
package rfe_pkg;

    localparam int ACTION_W = 2;
    localparam int COLOR_W  = 24;
    localparam int FADE_W   = 24;
    localparam int CHAN_W   = 8;

    // Action codes of a command beat
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COLOR_W-1:0]  new_color;
        logic [FADE_W-1:0]   fade_time;
    } cmd_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              still_fading;
    } res_t;

endpackage

### hw/rtl/rgb_fade_ease_in_out.sv
// ----------------------------------------------------------------------------
// rgb_fade_ease_in_out: timed RGB fade engine with quadratic ease-in-out
// Holds the shown color and blends it toward a target over a number of ticks.
// ----------------------------------------------------------------------------
// Each command beat carries an action: tick, start fade, stop fade or set
// color. Start, stop and a tick while idle leave the block idle and give no
// result. Set color, and a tick that ends the fade, pass through the send
// state and give one result beat. A tick inside a fade runs a bit-serial
// divider, a serial squarer and a serial three-lane blend back to back; the
// next beat is accepted only once those shift-and-add loops are through and
// the result is sent. Only one command is in flight at a time; a finished
// result waits in the output register while the next command is taken, and
// the block also stalls when a second result would have to overwrite one not
// yet taken.
module rgb_fade_ease_in_out #(
    parameter int TIME_BITS     = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  rfe_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output rfe_pkg::res_t  res
);

    localparam int CW = rfe_pkg::CHAN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_EASE = 3'd2;
    localparam logic [2:0] ST_MIX  = 3'd3;
    localparam logic [2:0] ST_SEND = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [rfe_pkg::COLOR_W-1:0] shown_reg, shown_next;
    logic [rfe_pkg::COLOR_W-1:0] start_reg, start_next;
    logic [rfe_pkg::COLOR_W-1:0] goal_reg, goal_next;
    logic [TIME_BITS-1:0]        elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]        length_reg, length_next;
    logic                        fading_reg, fading_next;
    logic                        res_valid_reg, res_valid_next;
    rfe_pkg::res_t               res_reg;

    logic                        accept;
    logic                        res_load;
    logic [TIME_BITS-1:0]        elapsed_inc;
    logic                        finished;
    logic                        div_start, ease_start, mix_start;
    logic                        div_done, ease_done, mix_done;
    logic [FRACTION_BITS-1:0]    prog;
    logic [FRACTION_BITS:0]      ease;
    logic [rfe_pkg::COLOR_W-1:0] mix_color;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    // Saturating elapsed count and end-of-fade check
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TIME_BITS'(1);
    assign finished    = (elapsed_inc >= length_reg);

    rfe_div #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_inc),
        .divisor  (length_reg),
        .quotient (prog),
        .done     (div_done)
    );

    rfe_ease #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ease (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ease_start),
        .prog  (prog),
        .ease  (ease),
        .done  (ease_done)
    );

    rfe_mix #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mix_start),
        .start_color (start_reg),
        .goal_color  (goal_reg),
        .ease        (ease),
        .color       (mix_color),
        .done        (mix_done)
    );

    // Sequence commands and the serial units
    always_comb
    begin
        state_next     = state_reg;
        shown_next     = shown_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        elapsed_next   = elapsed_reg;
        length_next    = length_reg;
        fading_next    = fading_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_load       = 1'b0;
        div_start      = 1'b0;
        ease_start     = 1'b0;
        mix_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        rfe_pkg::ACT_TICK:
                        begin
                            if (fading_reg)
                            begin
                                elapsed_next = elapsed_inc;
                                if (finished)
                                begin
                                    shown_next  = goal_reg;
                                    fading_next = 1'b0;
                                    state_next  = ST_SEND;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        rfe_pkg::ACT_START:
                        begin
                            start_next   = shown_reg;
                            goal_next    = cmd.new_color;
                            length_next  = TIME_BITS'(cmd.fade_time);
                            elapsed_next = '0;
                            fading_next  = 1'b1;
                        end
                        rfe_pkg::ACT_STOP:
                        begin
                            fading_next = 1'b0;
                        end
                        rfe_pkg::ACT_SET:
                        begin
                            shown_next = cmd.new_color;
                            state_next = ST_SEND;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ease_start = 1'b1;
                    state_next = ST_EASE;
                end
            end
            ST_EASE:
            begin
                if (ease_done)
                begin
                    mix_start  = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (mix_done)
                begin
                    shown_next = mix_color;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                // Load the result once the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_load       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold architectural state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shown_reg     <= '0;
            start_reg     <= '0;
            goal_reg      <= '0;
            elapsed_reg   <= '0;
            length_reg    <= '0;
            fading_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shown_reg     <= shown_next;
            start_reg     <= start_next;
            goal_reg      <= goal_next;
            elapsed_reg   <= elapsed_next;
            length_reg    <= length_next;
            fading_reg    <= fading_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Output register: shown color and fade flag of this beat
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg.red          <= shown_reg[3*CW-1:2*CW];
            res_reg.green        <= shown_reg[2*CW-1:CW];
            res_reg.blue         <= shown_reg[CW-1:0];
            res_reg.still_fading <= fading_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // A new result beat only comes out of the send state
    a_res_from_send: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_SEND))
        else $error("result raised outside send state");

    // The fade stays active while the serial units work on a tick
    a_fading_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_EASE || state_reg == ST_MIX) |-> fading_reg)
        else $error("fade inactive during blend computation");

    // The divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result beat lost or changed");
`endif

endmodule

### hw/rtl/rfe_div.sv
// ----------------------------------------------------------------------------
// rfe_div: bit-serial restoring divider
// Computes floor(dividend * 2^FRACTION_BITS / divisor), one quotient bit per
// cycle, for dividend < divisor.
// ----------------------------------------------------------------------------
module rfe_div #(
    parameter int TIME_BITS     = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [TIME_BITS-1:0]     dividend,
    input  logic [TIME_BITS-1:0]     divisor,
    output logic [FRACTION_BITS-1:0] quotient,
    output logic                     done
);

    localparam int CNT_W = $clog2(FRACTION_BITS);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [TIME_BITS-1:0]     rem_reg;
    logic [FRACTION_BITS-1:0] quot_reg;

    logic [TIME_BITS:0]       shifted;
    logic [TIME_BITS:0]       trial;
    logic                     fits;

    // Shift remainder left and try to subtract the divisor
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = ~trial[TIME_BITS];

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRACTION_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
            quot_reg <= {quot_reg[FRACTION_BITS-2:0], fits};
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

### hw/rtl/rfe_ease.sv
// ----------------------------------------------------------------------------
// rfe_ease: serial quadratic ease-in-out
// Squares the folded progress with a shift-and-add multiplier, one bit per
// cycle, then maps it onto the ease curve.
// ----------------------------------------------------------------------------
module rfe_ease #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [FRACTION_BITS-1:0] prog,
    output logic [FRACTION_BITS:0]   ease,
    output logic                     done
);

    localparam int F     = FRACTION_BITS;
    localparam int CNT_W = $clog2(F);

    logic           busy_reg;
    logic           done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           hi_reg;
    logic [F-1:0]   x_reg;
    logic [F-1:0]   bits_reg;
    logic [2*F-1:0] acc_reg;
    logic [F:0]     ease_reg;

    logic [F:0]     one_q;
    logic [F:0]     u_full;
    logic [F-1:0]   x_in;
    logic [2*F-1:0] acc_nx;
    logic [F:0]     sq;

    // Fold the upper half: u = 1 - p
    assign one_q  = {1'b1, {F{1'b0}}};
    assign u_full = one_q - {1'b0, prog};
    assign x_in   = prog[F-1] ? u_full[F-1:0] : prog;

    // Shift-and-add step, multiplier bits MSB first
    assign acc_nx = {acc_reg[2*F-2:0], 1'b0} + (bits_reg[F-1] ? {{F{1'b0}}, x_reg} : '0);
    assign sq     = acc_nx[2*F-1:F-1];

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(F - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: multiplier shift register, accumulator, ease result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg   <= prog[F-1];
            x_reg    <= x_in;
            bits_reg <= x_in;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_nx;
            bits_reg <= {bits_reg[F-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                ease_reg <= hi_reg ? (one_q - sq) : sq;
            end
        end
    end

    assign ease = ease_reg;
    assign done = done_reg;

endmodule

### hw/rtl/rfe_mix.sv
// ----------------------------------------------------------------------------
// rfe_mix: serial three-channel blend
// Each lane forms start + floor((goal - start) * ease / 2^FRACTION_BITS),
// walking the ease bits MSB first, one bit per cycle.
// ----------------------------------------------------------------------------
module rfe_mix #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rfe_pkg::COLOR_W-1:0] start_color,
    input  logic [rfe_pkg::COLOR_W-1:0] goal_color,
    input  logic [FRACTION_BITS:0]     ease,
    output logic [rfe_pkg::COLOR_W-1:0] color,
    output logic                       done
);

    localparam int F     = FRACTION_BITS;
    localparam int CW    = rfe_pkg::CHAN_W;
    localparam int ACC_W = F + CW + 2;
    localparam int CNT_W = $clog2(F + 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [F:0]              bits_reg;
    logic signed [CW:0]      diff_reg [3];
    logic signed [ACC_W-1:0] acc_reg  [3];
    logic [rfe_pkg::COLOR_W-1:0] color_reg;

    logic signed [CW:0]      diff_in [3];
    logic signed [ACC_W-1:0] acc_nx  [3];
    logic [CW-1:0]           chan_nx [3];

    // Per-lane difference, accumulate step and final offset by start channel
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_in[i] = $signed({1'b0, goal_color[CW*i +: CW]})
                       - $signed({1'b0, start_color[CW*i +: CW]});
            acc_nx[i]  = (acc_reg[i] <<< 1)
                       + (bits_reg[F] ? {{(ACC_W-CW-1){diff_reg[i][CW]}}, diff_reg[i]}
                                      : '0);
            chan_nx[i] = start_color[CW*i +: CW] + acc_nx[i][F+CW-1:F];
        end
    end

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(F);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: ease bit shift register and lane accumulators
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bits_reg <= ease;
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= diff_in[i];
                acc_reg[i]  <= '0;
            end
        end
        else if (busy_reg)
        begin
            bits_reg <= {bits_reg[F-1:0], 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= acc_nx[i];
            end
            if (cnt_reg == '0)
            begin
                color_reg <= {chan_nx[2], chan_nx[1], chan_nx[0]};
            end
        end
    end

    assign color = color_reg;
    assign done  = done_reg;

endmodule
